[rtl/reduplication_pattern_detector_defines.svh]
// assertion macros for the reduplication pattern detector
`ifndef REDUPLICATION_PATTERN_DETECTOR_DEFINES_SVH
`define REDUPLICATION_PATTERN_DETECTOR_DEFINES_SVH

// property checked on every rising edge of clk_i outside reset
`define RPD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define RPD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rpd_pkg.sv]
// shared constants and types of the reduplication pattern detector
`default_nettype none

package rpd_pkg;

  localparam int MAX_LEN    = 8;
  localparam int MIN_LEN    = 4;
  localparam int CLASS_BITS = 20;

  localparam int CODE_W = 21;
  localparam int CLS_W  = 20;
  localparam int MASK_W = 3;

  localparam int H_MAX  = MAX_LEN / 2;
  localparam int FULL_W = ((H_MAX - 1) > MASK_W) ? (H_MAX - 1) : MASK_W;
  localparam int IDX_W  = $clog2(MAX_LEN);
  localparam int FILL_W = $clog2(MAX_LEN + 1);

  localparam logic [CLS_W-1:0] CLASS_MASK = CLS_W'((64'd1 << CLASS_BITS) - 64'd1);

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [CLS_W-1:0]  cls_t;
  typedef logic [MASK_W-1:0] mask_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [FILL_W-1:0] fill_t;

  // window status toward the top level
  typedef struct packed {
    idx_t  fill;   // characters held before the current beat
    fill_t cnt;    // characters held once the current beat is appended
    logic  flush;  // current beat ends the text
  } win_ctrl_t;

  // result batch handed to the output buffer
  typedef struct packed {
    logic  valid;
    fill_t cnt;
    logic  flush;
  } res_load_t;

endpackage

`default_nettype wire

[rtl/rpd_in_if.sv]
// input character channel
`default_nettype none

interface rpd_in_if;
  import rpd_pkg::*;

  logic  valid;
  logic  ready;
  code_t char_code;
  cls_t  class_bits;
  logic  end_of_text;

  modport source (output valid, output char_code, output class_bits, output end_of_text,
                  input ready);
  modport sink (input valid, input char_code, input class_bits, input end_of_text,
                output ready);
endinterface

`default_nettype wire

[rtl/rpd_out_if.sv]
// result channel
`default_nettype none

interface rpd_out_if;
  import rpd_pkg::*;

  logic  valid;
  logic  ready;
  mask_t match_mask;
  logic  final_result;

  modport source (output valid, output match_mask, output final_result, input ready);
  modport sink (input valid, input match_mask, input final_result, output ready);
endinterface

`default_nettype wire

[rtl/rpd_cfg_if.sv]
// configuration write channel
`default_nettype none

interface rpd_cfg_if;
  import rpd_pkg::*;

  logic valid;
  logic ready;
  cls_t start_class_mask;

  modport source (output valid, output start_class_mask, input ready);
  modport sink (input valid, input start_class_mask, output ready);
endinterface

`default_nettype wire

[rtl/rpd_window.sv]
// sliding character window with append, shift and flush
`default_nettype none

module rpd_window (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               adv_i,
  input  wire rpd_pkg::code_t     code_i,
  input  wire rpd_pkg::cls_t      cls_i,
  input  wire logic               last_i,
  output rpd_pkg::code_t          chars_o [rpd_pkg::MAX_LEN],
  output rpd_pkg::cls_t           classes_o [rpd_pkg::MAX_LEN],
  output rpd_pkg::win_ctrl_t      ctrl_o
);
  import rpd_pkg::*;

  code_t chars_q [MAX_LEN];
  cls_t  classes_q [MAX_LEN];
  code_t chars_d [MAX_LEN];
  cls_t  classes_d [MAX_LEN];
  idx_t  fill_q, fill_d;
  fill_t cnt;
  logic  full;

  // window with the incoming beat written at the fill position
  always_comb begin
    for (int i = 0; i < MAX_LEN; i++) begin
      chars_o[i]   = (IDX_W'(i) == fill_q) ? code_i : chars_q[i];
      classes_o[i] = (IDX_W'(i) == fill_q) ? cls_i  : classes_q[i];
    end
  end

  assign cnt  = FILL_W'(fill_q) + FILL_W'(1);
  assign full = (cnt == FILL_W'(MAX_LEN));

  assign ctrl_o.fill  = fill_q;
  assign ctrl_o.cnt   = cnt;
  assign ctrl_o.flush = last_i;

  // oldest entry drops out once the window is full
  always_comb begin
    for (int i = 0; i < MAX_LEN - 1; i++) begin
      chars_d[i]   = full ? chars_o[i+1]   : chars_o[i];
      classes_d[i] = full ? classes_o[i+1] : classes_o[i];
    end
    chars_d[MAX_LEN-1]   = chars_o[MAX_LEN-1];
    classes_d[MAX_LEN-1] = classes_o[MAX_LEN-1];
  end

  always_comb begin
    if (last_i) begin
      fill_d = '0;
    end else if (full) begin
      fill_d = IDX_W'(MAX_LEN - 1);
    end else begin
      fill_d = cnt[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (adv_i) begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      chars_q   <= chars_d;
      classes_q <= classes_d;
    end
  end

endmodule

`default_nettype wire

[rtl/rpd_match.sv]
// per position half-length match masks over the window
`default_nettype none

module rpd_match (
  input  wire rpd_pkg::code_t  chars_i [rpd_pkg::MAX_LEN],
  input  wire rpd_pkg::cls_t   classes_i [rpd_pkg::MAX_LEN],
  input  wire rpd_pkg::fill_t  cnt_i,
  input  wire rpd_pkg::cls_t   start_mask_i,
  output rpd_pkg::mask_t       masks_o [rpd_pkg::MAX_LEN]
);
  import rpd_pkg::*;

  logic eq   [MAX_LEN][H_MAX+1];
  logic cok  [MAX_LEN][H_MAX+1];
  logic same [MAX_LEN][H_MAX+1];

  // character equality and class overlap at distance h
  for (genvar gi = 0; gi < MAX_LEN; gi++) begin : g_pair
    for (genvar gh = 0; gh <= H_MAX; gh++) begin : g_dist
      if (gh >= 1 && gi + gh < MAX_LEN) begin : g_on
        assign eq[gi][gh]  = (chars_i[gi] == chars_i[gi+gh]);
        assign cok[gi][gh] = |(classes_i[gi+gh] & classes_i[gi]);
      end else begin : g_off
        assign eq[gi][gh]  = 1'b0;
        assign cok[gi][gh] = 1'b0;
      end
    end
  end

  // both halves of length h equal
  for (genvar gk = 0; gk < MAX_LEN; gk++) begin : g_half
    for (genvar gh = 0; gh <= H_MAX; gh++) begin : g_len
      if (gh >= 2 && gk + 2 * gh <= MAX_LEN) begin : g_on
        logic [gh-1:0] eqv;
        for (genvar gp = 0; gp < gh; gp++) begin : g_bit
          assign eqv[gp] = eq[gk+gp][gh];
        end
        assign same[gk][gh] = &eqv;
      end else begin : g_off
        assign same[gk][gh] = 1'b0;
      end
    end
  end

  for (genvar gk = 0; gk < MAX_LEN; gk++) begin : g_pos
    fill_t             r;
    logic              run;
    logic [FULL_W-1:0] full;

    always_comb begin
      r = (cnt_i > FILL_W'(gk)) ? (cnt_i - FILL_W'(gk)) : '0;
      run = (r >= FILL_W'(MIN_LEN)) && (r >= FILL_W'(2)) &&
            (|(classes_i[gk] & start_mask_i)) && cok[gk][1];
      full = '0;
      // scan stops at the first h whose class check fails
      for (int h = 2; h <= H_MAX; h++) begin
        run = run && (r >= FILL_W'(2 * h)) && cok[gk][h];
        if (run && same[gk][h]) begin
          full[h-2] = 1'b1;
        end
      end
    end

    assign masks_o[gk] = full[MASK_W-1:0];
  end

endmodule

`default_nettype wire

[rtl/rpd_result_buf.sv]
// result batch register drained one beat per cycle while the sink is ready
`default_nettype none

module rpd_result_buf (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire rpd_pkg::res_load_t  load_i,
  input  wire rpd_pkg::mask_t      masks_i [rpd_pkg::MAX_LEN],
  output logic                     free_o,
  rpd_out_if.source                out_o
);
  import rpd_pkg::*;

  logic  valid_q;
  fill_t cnt_q;
  idx_t  idx_q;
  logic  flush_q;
  mask_t masks_q [MAX_LEN];
  logic  last_beat;
  logic  pop;

  assign last_beat = ((FILL_W'(idx_q) + FILL_W'(1)) == cnt_q);
  assign pop       = valid_q && out_o.ready;
  assign free_o    = !valid_q || (pop && last_beat);

  assign out_o.valid        = valid_q;
  assign out_o.match_mask   = masks_q[idx_q];
  assign out_o.final_result = flush_q && last_beat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
      idx_q   <= '0;
      flush_q <= 1'b0;
    end else if (load_i.valid) begin
      valid_q <= 1'b1;
      cnt_q   <= load_i.cnt;
      idx_q   <= '0;
      flush_q <= load_i.flush;
    end else if (pop) begin
      if (last_beat) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i.valid) begin
      masks_q <= masks_i;
    end
  end

endmodule

`default_nettype wire

[rtl/reduplication_pattern_detector.sv]
// top level of the reduplication pattern detector
`default_nettype none
`include "reduplication_pattern_detector_defines.svh"

// Finds ABAB repeats in a character stream. Each input beat carries one codepoint
// with its class bits; the block keeps the last MAX_LEN characters and emits, for every
// text position in order, a 3-bit mask whose bit h-2 is set when the h characters from
// that position are repeated by the next h (h = 2 .. MAX_LEN/2). A position qualifies
// only if its first character shares a class with start_class_mask, its second shares a
// class with the first, and the scan over h stops at the first h whose character at
// offset h shares no class with the first. One result leaves per input beat once the
// window is full; the beat flagged end_of_text resolves all held positions (up to
// MAX_LEN beats, the last with final_result set), where positions with fewer than
// MIN_LEN characters left give an empty mask. Throughput is one character per cycle
// apart from that flush and only while the output is ready, since the drain of the result
// batch (one beat per cycle from the result buffer) holds off the input stage. An input
// beat passes through the input register, then through the window compare into the
// result buffer. start_class_mask resets to zero and should be written while the block is idle.
module reduplication_pattern_detector (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rpd_in_if.sink    in_i,
  rpd_cfg_if.sink   cfg_i,
  rpd_out_if.source out_o
);
  import rpd_pkg::*;

  // configuration register
  cls_t start_mask_q;

  // input stage
  logic  in_valid_q;
  code_t in_code_q;
  cls_t  in_cls_q;
  logic  in_last_q;
  logic  adv;
  logic  buf_free;

  // window and match
  code_t     win_chars [MAX_LEN];
  cls_t      win_classes [MAX_LEN];
  win_ctrl_t win_ctrl;
  mask_t     masks [MAX_LEN];
  res_load_t res_load;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_mask_q <= '0;
    end else if (cfg_i.valid) begin
      start_mask_q <= cfg_i.start_class_mask & CLASS_MASK;
    end
  end

  // input register advances whenever the result buffer can take its batch
  assign adv        = in_valid_q && buf_free;
  assign in_i.ready = !in_valid_q || buf_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_code_q <= in_i.char_code;
      in_cls_q  <= in_i.class_bits & CLASS_MASK;
      in_last_q <= in_i.end_of_text;
    end
  end

  rpd_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .code_i    (in_code_q),
    .cls_i     (in_cls_q),
    .last_i    (in_last_q),
    .chars_o   (win_chars),
    .classes_o (win_classes),
    .ctrl_o    (win_ctrl)
  );

  rpd_match u_match (
    .chars_i      (win_chars),
    .classes_i    (win_classes),
    .cnt_i        (win_ctrl.cnt),
    .start_mask_i (start_mask_q),
    .masks_o      (masks)
  );

  // end of text flushes every held position, otherwise a full window emits its oldest
  always_comb begin
    res_load.flush = win_ctrl.flush;
    res_load.cnt   = win_ctrl.flush ? win_ctrl.cnt : FILL_W'(1);
    res_load.valid = adv && (win_ctrl.flush || (win_ctrl.cnt == FILL_W'(MAX_LEN)));
  end

  rpd_result_buf u_result_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (res_load),
    .masks_i(masks),
    .free_o (buf_free),
    .out_o  (out_o)
  );

  // window empties after the last character of a text
  `RPD_ASSERT_NEXT(a_flush_empties, adv && in_last_q, win_ctrl.fill == '0, "window not empty after flush")

  // window grows by one on an ordinary beat below full
  `RPD_ASSERT_NEXT(a_fill_grows, adv && !in_last_q && (win_ctrl.cnt != FILL_W'(MAX_LEN)), win_ctrl.fill == $past(win_ctrl.cnt[IDX_W-1:0]), "window fill count slipped")

  // a held input beat stays put while the result buffer is busy
  `RPD_ASSERT_NEXT(a_input_holds, in_valid_q && !buf_free, in_valid_q && $stable(in_code_q), "input stage lost a beat")

  // a batch is loaded only into a free result buffer
  `RPD_ASSERT(a_load_free, !res_load.valid || buf_free, "result batch overwrote pending beats")

endmodule

`default_nettype wire
